@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/eafp_pkg.sv @@
`default_nettype none

package eafp_pkg;

    // framing bytes
    localparam logic [7:0] START_DELIM = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;

    // frame types with captured fields
    localparam logic [7:0] TYPE_TX_STATUS      = 8'h8B;
    localparam logic [7:0] TYPE_AT_RESP        = 8'h88;
    localparam logic [7:0] TYPE_REMOTE_AT_RESP = 8'h97;
    localparam logic [7:0] TYPE_RX_PACKET      = 8'h90;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_CSUM_ERR  = 2'd2;
    localparam logic [1:0] KIND_ABORT     = 2'd3;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_CHECK  = 5'b10000
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_type;
        logic [7:0]  frame_id;
        logic [7:0]  status_byte;
        logic [63:0] source_address;
        logic [15:0] at_command;
        logic [15:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/eafp_parser.sv @@
`default_nettype none

module eafp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    output logic                   has_result,
    output eafp_pkg::result_t      result
);
    import eafp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  status_reg, status_next;
    logic [63:0] addr_reg, addr_next;
    logic [15:0] cmd_reg, cmd_next;

    // per-byte state update and result selection
    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] start;
        logic        abort;

        b           = rx_byte;
        start       = 16'd0;
        abort       = 1'b0;
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        id_next     = id_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        has_result  = 1'b0;
        result.kind = KIND_PAYLOAD;
        result.data_byte = 8'd0;

        if (rx_byte == START_DELIM)
        begin
            // start delimiter always opens a new frame
            abort       = (phase_reg != PH_HUNT);
            has_result  = abort;
            result.kind = KIND_ABORT;
            phase_next  = PH_LEN_HI;
            esc_next    = 1'b0;
            len_next    = 16'd0;
            pos_next    = 16'd0;
            sum_next    = 8'd0;
            type_next   = 8'd0;
            id_next     = 8'd0;
            status_next = 8'd0;
            addr_next   = 64'd0;
            cmd_next    = 16'd0;
        end
        else if (phase_reg == PH_HUNT)
        begin
            // ignore line noise between frames
        end
        else if (!esc_reg && rx_byte == ESCAPE_BYTE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            // unescape in place
            if (esc_reg)
            begin
                b = rx_byte ^ ESCAPE_XOR;
            end
            esc_next = 1'b0;

            case (phase_reg)
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {len_reg[15:8], b};
                    pos_next   = 16'd0;
                    phase_next = ({len_reg[15:8], b} != 16'd0) ? PH_BODY : PH_CHECK;
                end
                PH_BODY:
                begin
                    sum_next = sum_reg + b;
                    // field capture by body offset and type
                    if (pos_reg == 16'd0)
                    begin
                        type_next = b;
                    end
                    else
                    begin
                        if (pos_reg == 16'd1)
                        begin
                            id_next = b;
                        end
                        case (type_reg)
                            TYPE_TX_STATUS:
                            begin
                                if (pos_reg == 16'd5)
                                begin
                                    status_next = b;
                                end
                            end
                            TYPE_AT_RESP:
                            begin
                                if (pos_reg == 16'd2 || pos_reg == 16'd3)
                                begin
                                    cmd_next = {cmd_reg[7:0], b};
                                end
                                else if (pos_reg == 16'd4)
                                begin
                                    status_next = b;
                                end
                            end
                            TYPE_REMOTE_AT_RESP:
                            begin
                                if (pos_reg >= 16'd2 && pos_reg <= 16'd9)
                                begin
                                    addr_next = {addr_reg[55:0], b};
                                end
                                else if (pos_reg == 16'd12 || pos_reg == 16'd13)
                                begin
                                    cmd_next = {cmd_reg[7:0], b};
                                end
                                else if (pos_reg == 16'd14)
                                begin
                                    status_next = b;
                                end
                            end
                            TYPE_RX_PACKET:
                            begin
                                if (pos_reg >= 16'd1 && pos_reg <= 16'd8)
                                begin
                                    addr_next = {addr_reg[55:0], b};
                                end
                                else if (pos_reg == 16'd11)
                                begin
                                    status_next = b;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    // payload offset of the type seen so far
                    case (type_next)
                        TYPE_AT_RESP:        start = 16'd5;
                        TYPE_REMOTE_AT_RESP: start = 16'd15;
                        TYPE_RX_PACKET:      start = 16'd12;
                        default:             start = 16'd0;
                    endcase
                    if (start != 16'd0 && pos_reg >= start)
                    begin
                        has_result       = 1'b1;
                        result.kind      = KIND_PAYLOAD;
                        result.data_byte = b;
                    end
                    pos_next = pos_reg + 16'd1;
                    if (pos_next >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    sum_next    = sum_reg + b;
                    has_result  = 1'b1;
                    result.kind = (sum_next == SUM_GOOD) ? KIND_GOOD : KIND_CSUM_ERR;
                    phase_next  = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // abort reports fields held before the clear
        result.frame_type     = abort ? type_reg   : type_next;
        result.frame_id       = abort ? id_reg     : id_next;
        result.status_byte    = abort ? status_reg : status_next;
        result.source_address = abort ? addr_reg   : addr_next;
        result.at_command     = abort ? cmd_reg    : cmd_next;
        result.frame_length   = abort ? len_reg    : len_next;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            esc_reg    <= 1'b0;
            len_reg    <= 16'd0;
            pos_reg    <= 16'd0;
            sum_reg    <= 8'd0;
            type_reg   <= 8'd0;
            id_reg     <= 8'd0;
            status_reg <= 8'd0;
            addr_reg   <= 64'd0;
            cmd_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            id_reg     <= id_next;
            status_reg <= status_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/escaped_api_frame_parser.sv @@
// a byte accepted into the input register steps the parser, and any result it
// gives is captured in the output register; a full, stalled output holds it back
// throughput: one byte per cycle unless a full, stalled output holds the parser
// reset: asynchronous active-low; clears valid flags, parser returns to hunting
`default_nettype none

`include "assert_macros.svh"

module escaped_api_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       frame_type,
    output logic [7:0]       frame_id,
    output logic [7:0]       status_byte,
    output logic [63:0]      source_address,
    output logic [15:0]      at_command,
    output logic [15:0]      frame_length
);
    import eafp_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_fire;
    logic       has_result;
    result_t    result;
    logic       out_valid_reg;
    result_t    out_reg;

    // parser advances unless its result would hit a full, stalled output
    assign s1_fire  = s1_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    eafp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_fire),
        .rx_byte    (s1_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign data_byte      = out_reg.data_byte;
    assign frame_type     = out_reg.frame_type;
    assign frame_id       = out_reg.frame_id;
    assign status_byte    = out_reg.status_byte;
    assign source_address = out_reg.source_address;
    assign at_command     = out_reg.at_command;
    assign frame_length   = out_reg.frame_length;

    // checks on the pipeline control
    `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, out_valid_reg && out_stall, !(s1_fire && has_result))
    `ASSERT_NEXT(a_result_shown, clk, rst_n, s1_fire && has_result, out_valid_reg)
    `ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg && has_result)
    `ASSERT_IMPLY(a_data_only_payload, clk, rst_n, out_valid_reg && kind != KIND_PAYLOAD, data_byte == 8'd0)

endmodule

`default_nettype wire
